### design/linear_probe_hash_table_core_macros.svh
// Assertion macros shared by the hash table checker.
// Depends on a clock named clk and a synchronous active-high reset named rst in scope.
`ifndef LINEAR_PROBE_HASH_TABLE_CORE_MACROS_SVH
`define LINEAR_PROBE_HASH_TABLE_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define LPHT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define LPHT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/lpht_pkg.sv
// Shared types and constants for the linear probing hash table core.
// No dependencies; used by the controller, datapath, top level and checker.
`default_nettype none

package lpht_pkg;

  // Operation codes carried in req_type.
  typedef enum logic [1:0] {
    REQ_INSERT   = 2'd0,
    REQ_LOOKUP   = 2'd1,
    REQ_REMOVE   = 2'd2,
    REQ_CONTAINS = 2'd3
  } req_type_t;

  // Slot occupancy codes kept in the slot memory.
  typedef enum logic [1:0] {
    ST_EMPTY = 2'd0,
    ST_LIVE  = 2'd1,
    ST_TOMB  = 2'd2
  } slot_state_t;

  localparam int unsigned FIELD_BITS      = 32;
  localparam int unsigned LIMIT_BITS      = 9;
  localparam logic [LIMIT_BITS-1:0] LOAD_LIMIT_RESET = 9'd192;

  // Home slot reduction by reciprocal multiplication takes two steps.
  localparam int unsigned HASH_STEPS = 2;
  localparam int unsigned HCNT_W     = $clog2(HASH_STEPS + 1);

  typedef struct packed {
    req_type_t              req_type;
    logic [FIELD_BITS-1:0]  key_hash;
    logic [FIELD_BITS-1:0]  key;
    logic [FIELD_BITS-1:0]  value;
  } req_t;

  typedef struct packed {
    logic                   status;
    logic                   found;
    logic                   new_key;
    logic [FIELD_BITS-1:0]  result_value;
    logic [LIMIT_BITS-1:0]  used_count;
  } rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear;
    logic load;
    logic hash_step;
    logic probe_init;
    logic probe_run;
    logic act;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_last;
    logic limit_refuse;
    logic hash_done;
    logic probe_end;
  } dp_sts_t;

endpackage

`default_nettype wire

### design/lpht_ctrl.sv
// Controller state machine for the hash table core.
// Depends on lpht_pkg for the command and status structs.
`default_nettype none

module lpht_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  lpht_pkg::dp_sts_t sts,
  output lpht_pkg::dp_cmd_t cmd,
  output logic              busy,
  output logic              done
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_PROBE,
    S_ACT
  } state_t;

  state_t state;

  assign busy = (state != S_IDLE);

  // Commands follow from the current state, start and the hash status.
  always_comb begin
    cmd = '0;
    case (state)
      S_CLEAR: cmd.clear = 1'b1;
      S_IDLE:  cmd.load  = start;
      S_HASH: begin
        cmd.probe_init = sts.hash_done;
        cmd.hash_step  = !sts.hash_done;
      end
      S_PROBE: cmd.probe_run = 1'b1;
      S_ACT:   cmd.act = 1'b1;
      default: cmd = '0;
    endcase
  end

  // State register and the result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_CLEAR: begin
          if (sts.clear_last) state <= S_IDLE;
        end
        S_IDLE: begin
          if (start) state <= sts.limit_refuse ? S_ACT : S_HASH;
        end
        S_HASH: begin
          if (sts.hash_done) state <= S_PROBE;
        end
        S_PROBE: begin
          if (sts.probe_end) state <= S_ACT;
        end
        S_ACT: begin
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

### design/lpht_dp.sv
// Datapath for the hash table core: slot memory, home slot reducer, probe
// pipeline, used count, load limit register and result register. Uses lpht_pkg.
`default_nettype none

module lpht_dp #(
  parameter int unsigned SLOTS      = 256,
  parameter int unsigned KEY_BITS   = 32,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  lpht_pkg::req_t                       req,
  input  logic                                 cfg_valid,
  input  logic [lpht_pkg::LIMIT_BITS-1:0]      cfg_data,
  output logic                                 cfg_ready,
  input  lpht_pkg::dp_cmd_t                    cmd,
  output lpht_pkg::dp_sts_t                    sts,
  output lpht_pkg::rsp_t                       rsp
);

  localparam int unsigned IDX_W   = $clog2(SLOTS);
  localparam int unsigned CNT_W   = $clog2(SLOTS + 1);
  localparam int unsigned LW      = ((CNT_W > lpht_pkg::LIMIT_BITS) ? CNT_W
                                     : lpht_pkg::LIMIT_BITS) + 1;
  localparam bit          IS_POW2 = ((SLOTS & (SLOTS - 1)) == 0);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

  // Reciprocal of the slot count, scaled so the quotient of any 32-bit hash is exact.
  localparam int unsigned      RSHIFT   = lpht_pkg::FIELD_BITS + IDX_W;
  localparam logic [64:0]      RECIP    = ((65'd1 << RSHIFT) + 65'(SLOTS) - 65'd1)
                                          / 65'(SLOTS);
  localparam logic [IDX_W-1:0] SLOTS_LO = IDX_W'(SLOTS);

  typedef struct packed {
    lpht_pkg::slot_state_t   st;
    logic [KEY_BITS-1:0]     key;
    logic [VALUE_BITS-1:0]   val;
  } slot_t;

  slot_t mem [SLOTS];

  // Request registers captured on the start transfer.
  lpht_pkg::req_type_t             op;
  logic [lpht_pkg::FIELD_BITS-1:0] hash_q;
  logic [KEY_BITS-1:0]             key_q;
  logic [VALUE_BITS-1:0]           val_q;

  // Control registers.
  logic [lpht_pkg::LIMIT_BITS-1:0] load_limit;
  logic [CNT_W-1:0]                count;
  logic [IDX_W-1:0]                clr_idx;
  logic [lpht_pkg::HCNT_W-1:0]     hcnt;
  logic [63:0]                     prod;
  logic [IDX_W-1:0]                rem;
  logic                            rvalid;

  // Probe pipeline registers.
  logic [IDX_W-1:0]                pidx;
  logic [IDX_W-1:0]                rd_idx;
  slot_t                           rdata;
  logic [IDX_W-1:0]                visited;
  logic                            have_tomb;
  logic [IDX_W-1:0]                tomb_idx;

  // Probe outcome.
  logic                            hit;
  logic                            pos_valid;
  logic                            pos_empty;
  logic [IDX_W-1:0]                pos;
  logic [VALUE_BITS-1:0]           hit_val;

  assign cfg_ready = 1'b1;

  // Load limit register.
  always_ff @(posedge clk) begin
    if (rst) begin
      load_limit <= lpht_pkg::LOAD_LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      load_limit <= cfg_data;
    end
  end

  // Insert admission check against the effective limit.
  logic [LW-1:0] cnt_ext;
  logic [LW-1:0] lim_ext;
  logic [LW-1:0] eff_lim;
  always_comb begin
    cnt_ext = LW'(count);
    lim_ext = LW'(load_limit);
    eff_lim = (lim_ext > LW'(SLOTS)) ? LW'(SLOTS) : lim_ext;
    sts.limit_refuse = (req.req_type == lpht_pkg::REQ_INSERT) &&
                       ((cnt_ext + LW'(1)) > eff_lim);
  end

  // Clearing pass after reset walks every slot once.
  assign sts.clear_last = (clr_idx == LAST_IDX);

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx <= '0;
    end else if (cmd.clear) begin
      clr_idx <= clr_idx + IDX_W'(1);
    end
  end

  // Capture the request on the start transfer.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op     <= req.req_type;
      hash_q <= req.key_hash;
      key_q  <= KEY_BITS'(req.key);
      val_q  <= VALUE_BITS'(req.value);
    end
  end

  // Home slot: a mask for a power of two slot count, else a remainder by
  // reciprocal multiplication. The first step forms the scaled product; the
  // second subtracts quotient times SLOTS, which only needs the low index bits.
  logic [63:0]      prod_next;
  logic [IDX_W-1:0] quot;
  logic [IDX_W-1:0] qd;
  logic [IDX_W-1:0] rem_next;
  always_comb begin
    prod_next = 64'(hash_q) * 64'(RECIP[31:0]);
    if (RECIP[32]) prod_next = prod_next + {hash_q, 32'd0};
    quot     = prod[RSHIFT +: IDX_W];
    qd       = quot * SLOTS_LO;
    rem_next = hash_q[IDX_W-1:0] - qd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hcnt <= '0;
    end else if (cmd.load) begin
      hcnt <= '0;
    end else if (cmd.hash_step) begin
      hcnt <= hcnt + lpht_pkg::HCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.hash_step) begin
      if (hcnt == lpht_pkg::HCNT_W'(0)) prod <= prod_next;
      else                              rem  <= rem_next;
    end
  end

  assign sts.hash_done = IS_POW2 || (hcnt == lpht_pkg::HCNT_W'(lpht_pkg::HASH_STEPS));

  logic [IDX_W-1:0] home;
  assign home = (op == lpht_pkg::REQ_CONTAINS) ? '0 :
                (IS_POW2 ? hash_q[IDX_W-1:0] : rem);

  // Evaluate the slot read in the previous cycle.
  logic is_empty;
  logic is_live;
  logic is_tomb;
  logic kmatch;
  logic vmatch;
  logic last;
  logic scan;
  always_comb begin
    scan     = (op == lpht_pkg::REQ_CONTAINS);
    is_empty = (rdata.st == lpht_pkg::ST_EMPTY);
    is_live  = (rdata.st == lpht_pkg::ST_LIVE);
    is_tomb  = !is_empty && !is_live;
    kmatch   = is_live && (rdata.key == key_q);
    vmatch   = is_live && (rdata.val == val_q);
    last     = (visited == LAST_IDX);
    if (scan) sts.probe_end = rvalid && (vmatch || last);
    else      sts.probe_end = rvalid && (is_empty || kmatch || last);
  end

  // Probe pipeline: read one slot per cycle while judging the previous one.
  always_ff @(posedge clk) begin
    if (rst) begin
      rvalid <= 1'b0;
    end else if (cmd.probe_init) begin
      rvalid <= 1'b0;
    end else if (cmd.probe_run) begin
      rvalid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.probe_init) begin
      pidx      <= home;
      visited   <= '0;
      have_tomb <= 1'b0;
    end else if (cmd.probe_run) begin
      rdata  <= mem[pidx];
      rd_idx <= pidx;
      pidx   <= (pidx == LAST_IDX) ? '0 : pidx + IDX_W'(1);
      if (rvalid) begin
        visited <= visited + IDX_W'(1);
        if (is_tomb && !have_tomb) begin
          have_tomb <= 1'b1;
          tomb_idx  <= rd_idx;
        end
      end
    end
  end

  // Latch the probe outcome when the probe ends.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      hit       <= 1'b0;
      pos_valid <= 1'b0;
      pos_empty <= 1'b0;
    end else if (cmd.probe_run && sts.probe_end) begin
      hit     <= scan ? vmatch : kmatch;
      hit_val <= rdata.val;
      if (!scan && kmatch) begin
        pos       <= rd_idx;
        pos_valid <= 1'b1;
        pos_empty <= 1'b0;
      end else if (!scan) begin
        pos_valid <= is_empty || have_tomb || is_tomb;
        pos_empty <= is_empty && !have_tomb;
        pos       <= have_tomb ? tomb_idx : rd_idx;
      end
    end
  end

  // Commit the operation: memory write, count update and result fields; the clearing pass writes here too.
  logic             is_ins;
  logic             wr_en;
  slot_t            wr_entry;
  logic [IDX_W-1:0] wr_addr;
  logic             ins_new;
  logic             ins_fail;
  logic [CNT_W-1:0] count_next;
  always_comb begin
    is_ins     = (op == lpht_pkg::REQ_INSERT);
    ins_new    = is_ins && !hit && pos_valid;
    ins_fail   = is_ins && !hit && !pos_valid;
    count_next = count + CNT_W'(ins_new && pos_empty);
    wr_en      = 1'b0;
    wr_addr    = pos;
    wr_entry   = '{st: lpht_pkg::ST_LIVE, key: key_q, val: val_q};
    if (cmd.clear) begin
      wr_en    = 1'b1;
      wr_addr  = clr_idx;
      wr_entry = '{st: lpht_pkg::ST_EMPTY, key: '0, val: '0};
    end else if (cmd.act) begin
      if (is_ins) begin
        wr_en = hit || pos_valid;
      end else if (op == lpht_pkg::REQ_REMOVE) begin
        wr_en    = hit;
        wr_entry = '{st: lpht_pkg::ST_TOMB, key: key_q, val: hit_val};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.act) begin
      count <= count_next;
    end
  end

  // Result register, shown with the done strobe.
  always_ff @(posedge clk) begin
    if (cmd.act) begin
      rsp.status     <= ins_fail;
      rsp.found      <= !is_ins && hit;
      rsp.new_key    <= ins_new;
      rsp.result_value <= (op == lpht_pkg::REQ_LOOKUP && hit)
                          ? lpht_pkg::FIELD_BITS'(hit_val)
                          : lpht_pkg::FIELD_BITS'(val_q);
      rsp.used_count <= lpht_pkg::LIMIT_BITS'(count_next);
    end
  end

endmodule

`default_nettype wire

### design/linear_probe_hash_table_core.sv
// Top level of the linear probing hash table core: controller plus datapath.
// Depends on lpht_pkg, lpht_ctrl and lpht_dp.
//
// Open-addressed key/value table with linear probing and tombstones. A request
// is taken when start is high and busy is low; its single result appears on rsp
// for exactly one cycle with done high, and the receiver cannot stall it. After
// reset the core clears the slot memory, one slot per cycle, and stays busy until
// the clearing pass ends. A new request is taken only once the previous one has
// finished. The probe reads one slot per cycle on the single read port, and the
// home slot is a mask of the hash when SLOTS is a power of two, else a remainder
// by reciprocal multiplication, then a multiply and subtract. A contains-value
// request walks the slots from index 0, up to SLOTS of them. An insert refused
// by the load limit skips hashing and probing and goes straight to the commit.
`default_nettype none

module linear_probe_hash_table_core #(
  parameter int unsigned SLOTS      = 256,
  parameter int unsigned KEY_BITS   = 32,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  lpht_pkg::req_t                  req,
  output logic                            done,
  output lpht_pkg::rsp_t                  rsp,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [lpht_pkg::LIMIT_BITS-1:0] cfg_data
);

  lpht_pkg::dp_cmd_t cmd;
  lpht_pkg::dp_sts_t sts;

  // Sequencer for the clear pass, hashing, probing and commit.
  lpht_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  // Slot storage and probe logic.
  lpht_dp #(
    .SLOTS      (SLOTS),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .cfg_ready (cfg_ready),
    .cmd       (cmd),
    .sts       (sts),
    .rsp       (rsp)
  );

endmodule

`default_nettype wire

### design/lpht_checker.sv
// Port-level checker for the hash table core, attached by bind.
// Depends on lpht_pkg and linear_probe_hash_table_core_macros.svh.
`default_nettype none
`include "linear_probe_hash_table_core_macros.svh"

module lpht_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            start,
  input logic                            busy,
  input logic                            done,
  input lpht_pkg::rsp_t                  rsp
);

  // A result is only presented once the core is free again.
  `LPHT_ASSERT_NOW(a_done_idle, done, !busy, "result strobe while busy")

  // An accepted transfer always starts work.
  `LPHT_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted request left core idle")

  // A result strobe lasts a single cycle.
  `LPHT_ASSERT_NEXT(a_done_pulse, done, !done, "result strobe held for two cycles")

  // A refused insert reports neither a hit nor a new key.
  `LPHT_ASSERT_NOW(a_refuse_clean, done && rsp.status, !rsp.found && !rsp.new_key,
    "refused insert flagged found or new key")

endmodule

bind linear_probe_hash_table_core lpht_checker u_chk (.*);

`default_nettype wire

### dv/lpht_table_checker.sv
// Checker for the linear probing hash table core: keeps its own copy of the table,
// predicts one response per accepted request and compares it with the core's output.
// Depends on lpht_pkg for the request, response and slot state types.
module lpht_table_checker #(
  parameter int unsigned SLOTS = 256
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic                            busy,
  input  lpht_pkg::req_t                  req,
  input  logic                            done,
  input  lpht_pkg::rsp_t                  rsp,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [lpht_pkg::LIMIT_BITS-1:0] cfg_data,
  output int                              mismatches,
  output int                              outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import lpht_pkg::*;

  localparam int unsigned REPORT_LIMIT = 10;

  // Outcomes of a probe sequence.
  localparam int PROBE_NONE = -1;
  localparam int PROBE_MISS = 0;
  localparam int PROBE_HIT  = 1;

  // Shadow copy of the table and of the load limit register.
  slot_state_t           slot_st [SLOTS];
  logic [FIELD_BITS-1:0] slot_key[SLOTS];
  logic [FIELD_BITS-1:0] slot_val[SLOTS];
  int unsigned           used_slots;
  logic [LIMIT_BITS-1:0] load_limit;

  // Responses predicted for accepted requests, oldest first.
  rsp_t predicted_rsp[$];

  // Walk from the home slot until an empty slot, a live key match, or a full lap.
  // On a miss, pos is the first tombstone met or else the empty slot that ended it.
  function automatic int probe_for(input logic [FIELD_BITS-1:0] hash,
                                   input logic [FIELD_BITS-1:0] key,
                                   output int unsigned pos);
    int unsigned idx;
    int unsigned tomb;
    bit          have_tomb;
    idx       = hash % SLOTS;
    tomb      = 0;
    have_tomb = 1'b0;
    pos       = 0;
    for (int i = 0; i < SLOTS; i++) begin
      if (slot_st[idx] == ST_EMPTY) begin
        pos = have_tomb ? tomb : idx;
        return PROBE_MISS;
      end
      if (slot_st[idx] == ST_LIVE) begin
        if (slot_key[idx] == key) begin
          pos = idx;
          return PROBE_HIT;
        end
      end else if (!have_tomb) begin
        have_tomb = 1'b1;
        tomb      = idx;
      end
      idx = (idx + 1) % SLOTS;
    end
    if (have_tomb) begin
      pos = tomb;
      return PROBE_MISS;
    end
    return PROBE_NONE;
  endfunction

  // Apply one request to the shadow table and return the response it should give.
  function automatic rsp_t predict_response(input req_t r);
    rsp_t        o;
    int unsigned pos;
    int unsigned cap;
    int          outcome;
    o              = '0;
    o.result_value = r.value;
    case (r.req_type)
      REQ_INSERT: begin
        cap = (int'(load_limit) > SLOTS) ? SLOTS : int'(load_limit);
        if (used_slots + 1 > cap) begin
          o.status = 1'b1;
        end else begin
          outcome = probe_for(r.key_hash, r.key, pos);
          if (outcome == PROBE_NONE) begin
            o.status = 1'b1;
          end else begin
            if (outcome == PROBE_MISS) begin
              o.new_key = 1'b1;
              if (slot_st[pos] == ST_EMPTY) used_slots++;
            end
            slot_st[pos]  = ST_LIVE;
            slot_key[pos] = r.key;
            slot_val[pos] = r.value;
          end
        end
      end
      REQ_LOOKUP: begin
        if (probe_for(r.key_hash, r.key, pos) == PROBE_HIT) begin
          o.found        = 1'b1;
          o.result_value = slot_val[pos];
        end
      end
      REQ_REMOVE: begin
        if (probe_for(r.key_hash, r.key, pos) == PROBE_HIT) begin
          o.found      = 1'b1;
          slot_st[pos] = ST_TOMB;
        end
      end
      default: begin
        // Contains-value looks at every live slot regardless of the probe order.
        for (int i = 0; i < SLOTS; i++) begin
          if (slot_st[i] == ST_LIVE && slot_val[i] == r.value) o.found = 1'b1;
        end
      end
    endcase
    o.used_count = LIMIT_BITS'(used_slots);
    return o;
  endfunction

  // Sample all channels at the rising edge; a response is compared before the
  // prediction of a request accepted at the same edge is queued.
  always @(posedge clk) begin : monitor
    rsp_t want;
    if (rst) begin
      foreach (slot_st[i]) slot_st[i] = ST_EMPTY;
      used_slots  = 0;
      load_limit  = LOAD_LIMIT_RESET;
      mismatches  = 0;
      predicted_rsp.delete();
    end else begin
      if (cfg_valid && cfg_ready) load_limit = cfg_data;
      if (done) begin
        if (predicted_rsp.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("%0t lpht_table_checker: response with no request outstanding", $time);
        end else begin
          want = predicted_rsp.pop_front();
          if (rsp.status !== want.status || rsp.found !== want.found ||
              rsp.new_key !== want.new_key || rsp.result_value !== want.result_value ||
              rsp.used_count !== want.used_count) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
              $display("%0t lpht_table_checker: expected status=%0b found=%0b new_key=%0b",
                       $time, want.status, want.found, want.new_key,
                       " value=%08h used=%0d", want.result_value, want.used_count);
              $display("%0t lpht_table_checker: actual   status=%0b found=%0b new_key=%0b",
                       $time, rsp.status, rsp.found, rsp.new_key,
                       " value=%08h used=%0d", rsp.result_value, rsp.used_count);
            end
          end
        end
      end
      if (start && !busy) predicted_rsp.push_back(predict_response(req));
    end
    outstanding = predicted_rsp.size();
  end

endmodule

### dv/tb.sv
// Top of the hash table core testbench: clock, reset, request and load limit stimulus,
// watchdog and verdict. Depends on lpht_pkg, linear_probe_hash_table_core and lpht_table_checker.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lpht_pkg::*;

  localparam int unsigned STALL_LIMIT   = 4000;
  localparam int unsigned SETTLE_CYCLES = 20;
  localparam int unsigned KEY_POOL      = 128;
  localparam int unsigned VALUE_POOL    = 16;
  localparam int unsigned GAP_PERCENT   = 13;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  start;
  logic                  busy;
  req_t                  req;
  logic                  done;
  rsp_t                  rsp;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [LIMIT_BITS-1:0] cfg_data;

  int          mismatches;
  int          outstanding;
  int unsigned quiet_cycles;
  bit          gaps_on;

  // Keys with fixed home slots, so repeated requests on a key probe the same run.
  logic [FIELD_BITS-1:0] pool_key  [KEY_POOL];
  logic [7:0]            pool_home [KEY_POOL];
  logic [FIELD_BITS-1:0] pool_value[VALUE_POOL];

  linear_probe_hash_table_core dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .req       (req),
    .done      (done),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  lpht_table_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .req         (req),
    .done        (done),
    .rsp         (rsp),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always #5ns clk = ~clk;

  // Watchdog: any transfer, response or register write restarts the count.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  function automatic req_t make_req(input req_type_t kind, input logic [31:0] hash,
                                    input logic [31:0] key, input logic [31:0] value);
    req_t r;
    r.req_type = kind;
    r.key_hash = hash;
    r.key      = key;
    r.value    = value;
    return r;
  endfunction

  // Request on one of the first span pool keys; three in twenty get a random hash, key or type.
  function automatic req_t pool_request(input int unsigned span);
    req_t        r;
    int unsigned i;
    int unsigned pick;
    i    = $urandom_range(0, span - 1);
    pick = $urandom_range(0, 99);
    r.req_type = (pick < 40) ? REQ_INSERT : (pick < 70) ? REQ_LOOKUP :
                 (pick < 88) ? REQ_REMOVE : REQ_CONTAINS;
    r.key      = pool_key[i];
    r.key_hash = {24'($urandom), pool_home[i]};
    r.value    = ($urandom_range(0, 9) < 7) ? pool_value[$urandom_range(0, VALUE_POOL - 1)]
                                            : $urandom;
    pick = $urandom_range(0, 19);
    if (pick == 0) r.key_hash = $urandom;
    if (pick == 1) r.key = $urandom;
    if (pick == 2) r.req_type = req_type_t'($urandom_range(0, 3));
    return r;
  endfunction

  // One request transfer, with random idle cycles before it when gaps are on.
  task automatic send(input req_t r);
    while (gaps_on && $urandom_range(0, 99) < GAP_PERCENT) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    req   <= r;
    do @(posedge clk); while (busy !== 1'b0);
    @(negedge clk);
  endtask

  // Wait until every predicted response has arrived, then let the core settle.
  task automatic settle();
    start <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_limit(input logic [LIMIT_BITS-1:0] limit);
    settle();
    cfg_data  <= limit;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    rst       = 1'b1;
    start     = 1'b0;
    req       = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    gaps_on   = 1'b1;

    // A quarter of the keys crowd slots 248 round to 7, so their runs wrap to slot 0.
    for (int i = 0; i < KEY_POOL; i++) begin
      pool_key[i]  = $urandom;
      pool_home[i] = (i % 4 == 0) ? 8'(248 + $urandom_range(0, 15))
                                  : {6'($urandom_range(0, 63)), 2'b00};
    end
    foreach (pool_value[i]) pool_value[i] = $urandom;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: empty table, collisions on slot 0, tombstone reuse, wrap past slot 255.
    send(make_req(REQ_LOOKUP,   32'h0000_0000, 32'h0000_1234, 32'hFFFF_FFFF));
    send(make_req(REQ_REMOVE,   32'h0000_0000, 32'h0000_1234, 32'h0000_0000));
    send(make_req(REQ_CONTAINS, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000));
    send(make_req(REQ_INSERT,   32'h0000_0000, 32'h0000_0000, 32'h0000_0000));
    send(make_req(REQ_INSERT,   32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send(make_req(REQ_INSERT,   32'h0000_0100, 32'h0000_000A, 32'h1111_1111));
    send(make_req(REQ_INSERT,   32'h0000_0000, 32'h0000_0000, 32'h5A5A_5A5A));
    send(make_req(REQ_LOOKUP,   32'h0000_0000, 32'h0000_0000, 32'h0000_0000));
    send(make_req(REQ_LOOKUP,   32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000));
    send(make_req(REQ_REMOVE,   32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000));
    send(make_req(REQ_LOOKUP,   32'h0000_0000, 32'h0000_000A, 32'h0000_0000));
    send(make_req(REQ_LOOKUP,   32'h0000_0000, 32'hFFFF_FFFF, 32'h7654_3210));
    send(make_req(REQ_INSERT,   32'h0000_0000, 32'h0000_000B, 32'h2222_2222));
    send(make_req(REQ_INSERT,   32'hFFFF_FFFF, 32'h0000_000C, 32'h8000_0001));
    send(make_req(REQ_INSERT,   32'h0000_00FF, 32'h0000_000D, 32'h3333_3333));
    send(make_req(REQ_LOOKUP,   32'h0000_00FF, 32'h0000_000D, 32'h0000_0000));
    send(make_req(REQ_CONTAINS, 32'h0000_0000, 32'h0000_0000, 32'h5A5A_5A5A));
    send(make_req(REQ_CONTAINS, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF));
    send(make_req(REQ_REMOVE,   32'h0000_0000, 32'h0000_0000, 32'h0000_0000));
    send(make_req(REQ_REMOVE,   32'h0000_0000, 32'h0000_0000, 32'h0000_0000));
    send(make_req(REQ_INSERT,   32'h0000_0000, 32'h0000_0000, 32'h0000_0001));
    send(make_req(REQ_LOOKUP,   32'hFFFF_FFFF, 32'hDEAD_BEEF, 32'h0000_0000));

    // A zero limit refuses every insert, even an assign to a live key.
    write_limit(9'd0);
    send(make_req(REQ_INSERT, 32'h0000_0000, 32'h0000_0000, 32'h0000_0009));
    send(make_req(REQ_INSERT, 32'h0000_0040, 32'h0000_0099, 32'h0000_0009));
    send(make_req(REQ_LOOKUP, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000));
    write_limit(9'd1);
    send(make_req(REQ_INSERT, 32'h0000_0041, 32'h0000_0098, 32'h0000_0007));

    // Tight limit: once the count reaches the limit every insert is refused; tombstone reuse does not raise it.
    write_limit(9'd40);
    repeat (300) send(pool_request(64));

    // Default limit with the whole pool, the first stretch without idle cycles.
    write_limit(LOAD_LIMIT_RESET);
    gaps_on = 1'b0;
    repeat (150) send(pool_request(KEY_POOL));
    gaps_on = 1'b1;
    repeat (230) send(pool_request(KEY_POOL));

    // Limit above the slot count: fresh keys fill every slot.
    write_limit(9'd511);
    repeat (300) begin
      if ($urandom_range(0, 5) == 0) send(pool_request(KEY_POOL));
      else send(make_req(REQ_INSERT, $urandom, $urandom, $urandom));
    end

    // Full table: misses probe a whole lap without meeting an empty slot.
    write_limit(9'd256);
    repeat (150) begin
      case ($urandom_range(0, 3))
        0:       send(make_req(REQ_LOOKUP, $urandom, $urandom, $urandom));
        1:       send(make_req(REQ_REMOVE, $urandom, $urandom, $urandom));
        default: send(pool_request(KEY_POOL));
      endcase
    end

    settle();
    if (mismatches == 0 && outstanding == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+design
design/lpht_pkg.sv
design/lpht_ctrl.sv
design/lpht_dp.sv
design/linear_probe_hash_table_core.sv
design/lpht_checker.sv
dv/lpht_table_checker.sv
dv/tb.sv
